### rtl/ks_pkg.sv
// ----------------------------------------------------------------------------
// ks_pkg
// Shared types, state codes and helper functions of the Kronecker symbol core.
// ----------------------------------------------------------------------------
`default_nettype none

package ks_pkg;

  localparam int WORD_W = 64;

  typedef logic [WORD_W-1:0] word_t;

  // symbol encodings on the result port
  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_SHR = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    word_t   opa;
    word_t   opb;
  } alu_req_t;

  typedef struct packed {
    word_t res;
    logic  borrow;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INIT  = 5'b00010,
    S_STRIP = 5'b00100,
    S_ABS   = 5'b01000,
    S_LOOP  = 5'b10000
  } state_t;

  // true for residues 3 and 5 mod 8, where (2/m) is -1
  function automatic logic mod8_flip(input logic [2:0] r);
    mod8_flip = (r == 3'd3) || (r == 3'd5);
  endfunction

  function automatic logic signed [1:0] encode_symbol(input logic zero, input logic neg);
    if (zero) begin
      encode_symbol = SYM_ZERO;
    end else if (neg) begin
      encode_symbol = SYM_NEG;
    end else begin
      encode_symbol = SYM_POS;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/ks_alu.sv
// ----------------------------------------------------------------------------
// ks_alu
// Shared 64-bit subtract / right-shift unit of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ks_alu import ks_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [WORD_W:0] diff;

  assign diff = {1'b0, req.opa} - {1'b0, req.opb};

  always_comb begin
    case (req.op)
      ALU_SHR: begin
        rsp.res    = {1'b0, req.opa[WORD_W-1:1]};
        rsp.borrow = 1'b0;
      end
      default: begin
        rsp.res    = diff[WORD_W-1:0];
        rsp.borrow = diff[WORD_W];
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/kronecker_symbol_core.sv
// ----------------------------------------------------------------------------
// kronecker_symbol_core
// Kronecker symbol (a/n) of two signed 64-bit operands, binary Jacobi method.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operand_a and modulus_n and raise start. The operands are taken at
//   a rising edge where start is high and busy is low; busy then stays high
//   until the result is out.
//   The result appears on symbol_value (-1, 0 or 1, two's complement) for
//   exactly one cycle, marked by done. The receiver cannot stall the block;
//   the result must be captured while done is high.
//   Sequence: a setup step that also takes |n|, then a halving step per factor
//   of two in n plus a step that finds n odd, a step to take |a|, then the
//   reduction loop, where each step either halves x, swaps x and n, or
//   subtracts n from x. The loop runs through the one shared 64-bit
//   subtract/shift unit. Trivial cases (n equal to 0 or 1, both operands
//   even) finish in the setup step.
//   A new transfer may start in the cycle that done is high.
//   Reset (rst, synchronous) abandons any item in progress and returns the
//   block to idle with done low.
// ----------------------------------------------------------------------------
`default_nettype none

module kronecker_symbol_core import ks_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] modulus_n,
  output logic               done,
  output logic signed [1:0]  symbol_value
);

  state_t   state;
  word_t    a_reg;
  word_t    n_reg;
  word_t    x_reg;
  logic     neg;
  logic     twos_odd;
  alu_req_t req;
  alu_rsp_t rsp;
  logic     strip_neg;

  ks_alu u_alu (
    .req(req),
    .rsp(rsp)
  );

  assign busy      = (state != S_IDLE);
  assign strip_neg = neg ^ (twos_odd & mod8_flip(a_reg[2:0]));

  // operand selection for the shared unit
  always_comb begin
    req.op  = ALU_SUB;
    req.opa = x_reg;
    req.opb = n_reg;
    unique case (state)
      S_INIT: begin
        req.opa = '0;
        req.opb = n_reg;
      end
      S_STRIP: begin
        req.op  = ALU_SHR;
        req.opa = n_reg;
      end
      S_ABS: begin
        req.opa = '0;
        req.opb = a_reg;
      end
      S_LOOP: begin
        if (!x_reg[0]) begin
          req.op = ALU_SHR;
        end
      end
      default: begin
        req.op = ALU_SUB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            a_reg <= operand_a;
            n_reg <= modulus_n;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          neg      <= n_reg[WORD_W-1] & a_reg[WORD_W-1];
          twos_odd <= 1'b0;
          if (n_reg == '0) begin
            symbol_value <= encode_symbol(
              !((a_reg == word_t'(1)) || (a_reg == '1)), 1'b0);
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (n_reg == word_t'(1)) begin
            symbol_value <= SYM_POS;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else if (!n_reg[0] && !a_reg[0]) begin
            symbol_value <= SYM_ZERO;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            // take |n|
            if (n_reg[WORD_W-1]) begin
              n_reg <= rsp.res;
            end
            state <= S_STRIP;
          end
        end
        S_STRIP: begin
          if (!n_reg[0]) begin
            n_reg    <= rsp.res;
            twos_odd <= !twos_odd;
          end else begin
            neg <= strip_neg;
            if (n_reg == word_t'(1)) begin
              symbol_value <= encode_symbol(1'b0, strip_neg);
              done         <= 1'b1;
              state        <= S_IDLE;
            end else begin
              state <= S_ABS;
            end
          end
        end
        S_ABS: begin
          // (-1/n) is -1 for n = 3 mod 4
          x_reg <= a_reg[WORD_W-1] ? rsp.res : a_reg;
          neg   <= neg ^ (a_reg[WORD_W-1] & (n_reg[1:0] == 2'b11));
          state <= S_LOOP;
        end
        S_LOOP: begin
          if (x_reg == '0) begin
            symbol_value <= encode_symbol(n_reg != word_t'(1), neg);
            done         <= 1'b1;
            state        <= S_IDLE;
          end else if (!x_reg[0]) begin
            x_reg <= rsp.res;
            neg   <= neg ^ mod8_flip(n_reg[2:0]);
          end else if (rsp.borrow) begin
            // reciprocity swap, both odd
            x_reg <= n_reg;
            n_reg <= x_reg;
            neg   <= neg ^ ((x_reg[1:0] == 2'b11) & (n_reg[1:0] == 2'b11));
          end else begin
            x_reg <= rsp.res;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
